>>> rtl/core/lsharp_pkg.sv
// shared constants and the sharpening arithmetic for the laplacian sharpening block
`default_nettype none

package lsharp_pkg;

	localparam int PIX_W             = 8;
	localparam int FW_W              = 11;
	localparam int FH_W              = 16;
	localparam int IN_ROW_W          = FH_W + 1;
	localparam int NSUM_W            = 11;
	localparam int CFG_IDX_W         = 2;
	localparam int CFG_DATA_W        = 16;
	localparam int MAX_WIDTH_DEFAULT = 1024;

	localparam logic [FW_W-1:0] FW_RESET = 11'd1024;
	localparam logic [FH_W-1:0] FH_RESET = 16'd1024;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

	localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

	// centre plus clamped |8*centre - neighbour sum|, saturated
	function automatic logic [PIX_W-1:0] sharpen(input logic [PIX_W-1:0] centre,
		input logic [NSUM_W-1:0] nsum);
		logic signed [NSUM_W:0] lap;
		logic [NSUM_W-1:0]      mag;
		logic [PIX_W:0]         sum;
		lap = $signed({1'b0, centre, 3'b000}) - $signed({1'b0, nsum});
		mag = lap[NSUM_W] ? NSUM_W'(-lap) : NSUM_W'(lap);
		if (mag > NSUM_W'(PIX_MAX)) begin
			mag = NSUM_W'(PIX_MAX);
		end
		sum = {1'b0, mag[PIX_W-1:0]} + {1'b0, centre};
		return sum[PIX_W] ? PIX_MAX : sum[PIX_W-1:0];
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/laplacian_sharpen_3x3.sv
// top level of the streaming 3x3 laplacian sharpening filter
//
// pixels enter on the slave stream in raster order: s_tdata is the gray value,
// s_tuser is 1 for a flush item that carries no pixel. results leave on the
// master stream: m_tdata is the sharpened value, m_tlast marks the last pixel
// of a line and m_tuser the last pixel of the frame. a result belongs to the
// item that came frame_width+1 items earlier, so after the last pixel of a
// frame the source sends frame_width+1 flush items to drain it.
// one item is taken every cycle unless the receiver stalls; an item waits in
// the input stage for the output register. the two line stores set the rate
// by their column access, one read and one write per item on separate ports.
// frame width and height are set through the cfg channel, which is always
// ready; the user writes it only while idle, the block does not enforce it.
// reset clears the counters, the 3x3 window and the output valid and loads
// a 1024 x 1024 frame; the line stores need no clearing pass.
// when the receiver stalls, the output register holds its item and the
// input stage holds one more; s_tready then drops until m_tready returns.
`default_nettype none

module laplacian_sharpen_3x3 #(
	parameter int MAX_WIDTH = lsharp_pkg::MAX_WIDTH_DEFAULT
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [lsharp_pkg::PIX_W-1:0]      s_tdata,   // pixel_in
	input  wire logic                              s_tuser,   // mode
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic      [lsharp_pkg::PIX_W-1:0]      m_tdata,   // pixel_out
	output logic                                   m_tlast,   // line_end
	output logic                                   m_tuser,   // frame_end
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [lsharp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [lsharp_pkg::CFG_DATA_W-1:0] cfg_data
);

	import lsharp_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int W_W   = $clog2(MAX_WIDTH + 1);

	typedef struct packed {
		logic             top_en;
		logic             mid_en;
		logic             col0;
		logic             emit;
		logic             le;
		logic             fe;
		logic [PIX_W-1:0] bot;
	} ctl_t;

	logic [FW_W-1:0]     frame_width_q;
	logic [FH_W-1:0]     frame_height_q;
	logic [COL_W-1:0]    in_col_q;
	logic [IN_ROW_W-1:0] in_row_q;
	logic [COL_W-1:0]    out_col_q;
	logic [FH_W-1:0]     out_row_q;

	logic                valid_s1;
	ctl_t                ctl_s1;
	logic [COL_W-1:0]    col_s1;

	logic [PIX_W-1:0]    win_q [3][3];
	logic [PIX_W-1:0]    win_d [3][3];

	logic                out_valid_q;
	logic [PIX_W-1:0]    pix_q;
	logic                le_q;
	logic                fe_q;

	logic                accept;
	logic                adv;
	logic [W_W-1:0]      w_eff;
	logic [FH_W-1:0]     h_eff;
	logic [COL_W-1:0]    c;
	logic                last_col;
	ctl_t                ctl_d;

	logic [PIX_W-1:0]    upper_rd;
	logic [PIX_W-1:0]    middle_rd;
	logic [PIX_W-1:0]    new_col [3];
	logic [PIX_W-1:0]    sh_col  [3][3];
	logic [NSUM_W-1:0]   nsum;
	logic [PIX_W-1:0]    result;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FW_RESET;
			frame_height_q <= FH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data[FW_W-1:0];
				CFG_FRAME_HEIGHT: frame_height_q <= cfg_data[FH_W-1:0];
				default: ;
			endcase
		end
	end

	// effective frame size and the column and flags of the item at the input
	always_comb begin
		if (frame_width_q == '0) begin
			w_eff = W_W'(1);
		end else if (32'(frame_width_q) > MAX_WIDTH) begin
			w_eff = W_W'(MAX_WIDTH);
		end else begin
			w_eff = W_W'(frame_width_q);
		end
		h_eff = (frame_height_q == '0) ? FH_W'(1) : frame_height_q;

		if (W_W'(in_col_q) >= w_eff) begin
			c = COL_W'(w_eff - W_W'(1));
		end else begin
			c = in_col_q;
		end
		last_col = (W_W'(c) + W_W'(1)) >= w_eff;

		ctl_d.top_en = (in_row_q >= IN_ROW_W'(2))
			&& ((in_row_q - IN_ROW_W'(2)) < IN_ROW_W'(h_eff));
		ctl_d.mid_en = (in_row_q != '0)
			&& ((in_row_q - IN_ROW_W'(1)) < IN_ROW_W'(h_eff));
		ctl_d.bot    = (!s_tuser && (in_row_q < IN_ROW_W'(h_eff))) ? s_tdata : '0;
		ctl_d.col0   = (c == '0);
		ctl_d.emit   = (in_row_q >= IN_ROW_W'(2))
			|| ((in_row_q == IN_ROW_W'(1)) && (c != '0));
		ctl_d.le     = (W_W'(out_col_q) + W_W'(1)) >= w_eff;
		ctl_d.fe     = ctl_d.le
			&& ((IN_ROW_W'(out_row_q) + IN_ROW_W'(1)) >= IN_ROW_W'(h_eff));
	end

	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (accept) begin
			if (ctl_d.emit && ctl_d.fe) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (last_col) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + IN_ROW_W'(1);
				end else begin
					in_col_q <= c + COL_W'(1);
				end
				if (ctl_d.emit) begin
					if (ctl_d.le) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + FH_W'(1);
					end else begin
						out_col_q <= out_col_q + COL_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1 <= ctl_d;
			col_s1 <= c;
		end
	end

	lsharp_line_store #(
		.DEPTH  (MAX_WIDTH),
		.ADDR_W (COL_W)
	) u_line_store (
		.clk       (clk),
		.rd_en     (accept),
		.rd_addr   (c),
		.wr_en     (adv),
		.wr_addr   (col_s1),
		.wr_upper  (middle_rd),
		.wr_middle (ctl_s1.bot),
		.upper_rd  (upper_rd),
		.middle_rd (middle_rd)
	);

	// shifted window, right column zero on the first column of a line
	always_comb begin
		new_col[0] = ctl_s1.top_en ? upper_rd : '0;
		new_col[1] = ctl_s1.mid_en ? middle_rd : '0;
		new_col[2] = ctl_s1.bot;
		for (int r = 0; r < 3; r++) begin
			sh_col[0][r] = win_q[1][r];
			sh_col[1][r] = win_q[2][r];
			sh_col[2][r] = ctl_s1.col0 ? '0 : new_col[r];
		end
		nsum = NSUM_W'(sh_col[0][0]) + NSUM_W'(sh_col[0][1]) + NSUM_W'(sh_col[0][2])
			+ NSUM_W'(sh_col[1][0]) + NSUM_W'(sh_col[1][2])
			+ NSUM_W'(sh_col[2][0]) + NSUM_W'(sh_col[2][1]) + NSUM_W'(sh_col[2][2]);
		result = sharpen(sh_col[1][1], nsum);

		for (int k = 0; k < 3; k++) begin
			for (int r = 0; r < 3; r++) begin
				if (ctl_s1.emit && ctl_s1.fe) begin
					win_d[k][r] = '0;
				end else if (ctl_s1.col0) begin
					win_d[k][r] = (k == 2) ? new_col[r] : '0;
				end else begin
					win_d[k][r] = sh_col[k][r];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				for (int r = 0; r < 3; r++) begin
					win_q[k][r] <= '0;
				end
			end
		end else if (adv) begin
			win_q <= win_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && ctl_s1.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && ctl_s1.emit) begin
			pix_q <= result;
			le_q  <= ctl_s1.le;
			fe_q  <= ctl_s1.fe;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = pix_q;
	assign m_tlast  = le_q;
	assign m_tuser  = fe_q;

endmodule

`default_nettype wire

>>> rtl/core/lsharp_line_store.sv
// upper and middle line stores with registered read and write forwarding
`default_nettype none

module lsharp_line_store #(
	parameter int DEPTH  = lsharp_pkg::MAX_WIDTH_DEFAULT,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic                         clk,
	input  wire logic                         rd_en,
	input  wire logic [ADDR_W-1:0]            rd_addr,
	input  wire logic                         wr_en,
	input  wire logic [ADDR_W-1:0]            wr_addr,
	input  wire logic [lsharp_pkg::PIX_W-1:0] wr_upper,
	input  wire logic [lsharp_pkg::PIX_W-1:0] wr_middle,
	output logic      [lsharp_pkg::PIX_W-1:0] upper_rd,
	output logic      [lsharp_pkg::PIX_W-1:0] middle_rd
);

	import lsharp_pkg::*;

	logic [PIX_W-1:0] upper_mem  [DEPTH];
	logic [PIX_W-1:0] middle_mem [DEPTH];
	logic [PIX_W-1:0] upper_q;
	logic [PIX_W-1:0] middle_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			upper_mem[wr_addr]  <= wr_upper;
			middle_mem[wr_addr] <= wr_middle;
		end
	end

	// a write in the same cycle to the same column wins over the old entry
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				upper_q  <= wr_upper;
				middle_q <= wr_middle;
			end else begin
				upper_q  <= upper_mem[rd_addr];
				middle_q <= middle_mem[rd_addr];
			end
		end
	end

	assign upper_rd  = upper_q;
	assign middle_rd = middle_q;

endmodule

`default_nettype wire

>>> test/sharpen_check.sv
// checker: predicts the sharpened pixel stream from accepted items and compares the block's results
module sharpen_check (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	input  wire logic                              s_tready,
	input  wire logic [lsharp_pkg::PIX_W-1:0]      s_tdata,   // pixel_in
	input  wire logic                              s_tuser,   // mode
	input  wire logic                              m_tvalid,
	input  wire logic                              m_tready,
	input  wire logic [lsharp_pkg::PIX_W-1:0]      m_tdata,   // pixel_out
	input  wire logic                              m_tlast,   // line_end
	input  wire logic                              m_tuser,   // frame_end
	input  wire logic                              cfg_valid,
	input  wire logic                              cfg_ready,
	input  wire logic [lsharp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [lsharp_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                                     fails,
	output int                                     pending
);
	import lsharp_pkg::*;

	typedef struct packed {
		logic [PIX_W-1:0] value;
		logic             line_end;
		logic             frame_end;
	} sharp_px_t;

	logic [FW_W-1:0]  frame_w_reg;
	logic [FH_W-1:0]  frame_h_reg;
	bit   [PIX_W-1:0] upper_line [MAX_WIDTH_DEFAULT];
	bit   [PIX_W-1:0] middle_line [MAX_WIDTH_DEFAULT];
	logic [PIX_W-1:0] win [3][3];   // [left, centre, right][top, mid, bottom]
	int unsigned      in_col, in_row, out_col, out_row;
	sharp_px_t        due_px [$];
	sharp_px_t        got, want;

	task automatic clear_window();
		for (int k = 0; k < 3; k++) begin
			for (int j = 0; j < 3; j++) begin
				win[k][j] = '0;
			end
		end
	endtask

	task automatic shift_in(input logic [PIX_W-1:0] top, input logic [PIX_W-1:0] mid,
		input logic [PIX_W-1:0] bot);
		for (int j = 0; j < 3; j++) begin
			win[0][j] = win[1][j];
			win[1][j] = win[2][j];
		end
		win[2][0] = top;
		win[2][1] = mid;
		win[2][2] = bot;
	endtask

	function automatic logic [PIX_W-1:0] window_sharp();
		int centre, acc;
		centre = win[1][1];
		acc = 8 * centre;
		for (int k = 0; k < 3; k++) begin
			for (int j = 0; j < 3; j++) begin
				if (k != 1 || j != 1) begin
					acc -= win[k][j];
				end
			end
		end
		if (acc < 0) begin
			acc = -acc;
		end
		if (acc > 255) begin
			acc = 255;
		end
		acc += centre;
		if (acc > 255) begin
			acc = 255;
		end
		return PIX_W'(acc);
	endfunction

	task automatic sharpen_pixel(input logic flush, input logic [PIX_W-1:0] pix);
		int unsigned      w, h, c, r;
		logic [PIX_W-1:0] top, mid, bot, lap;
		logic             emit, le, fe;
		w = frame_w_reg;
		h = frame_h_reg;
		if (w < 1) begin
			w = 1;
		end
		if (w > MAX_WIDTH_DEFAULT) begin
			w = MAX_WIDTH_DEFAULT;
		end
		if (h < 1) begin
			h = 1;
		end
		c = (in_col >= w) ? w - 1 : in_col;
		r = in_row;
		top = (r >= 2 && r - 2 < h) ? upper_line[c] : '0;
		mid = (r >= 1 && r - 1 < h) ? middle_line[c] : '0;
		bot = (!flush && r < h) ? pix : '0;
		upper_line[c] = middle_line[c];
		middle_line[c] = bot;
		emit = (r >= 2) || (r == 1 && c >= 1);
		if (c == 0) begin
			// finish the previous line against a zero right column
			shift_in('0, '0, '0);
			lap = window_sharp();
			clear_window();
			win[2][0] = top;
			win[2][1] = mid;
			win[2][2] = bot;
		end else begin
			shift_in(top, mid, bot);
			lap = window_sharp();
		end
		if (c + 1 >= w) begin
			in_col = 0;
			in_row = r + 1;
		end else begin
			in_col = c + 1;
			in_row = r;
		end
		if (emit) begin
			le = (out_col + 1 >= w);
			fe = le && (out_row + 1 >= h);
			due_px.push_back({lap, le, fe});
			if (le) begin
				out_col = 0;
				out_row++;
			end else begin
				out_col++;
			end
			if (fe) begin
				in_col = 0;
				in_row = 0;
				out_col = 0;
				out_row = 0;
				clear_window();
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_w_reg = FW_RESET;
			frame_h_reg = FH_RESET;
			clear_window();
			in_col = 0;
			in_row = 0;
			out_col = 0;
			out_row = 0;
			due_px.delete();
			fails = 0;
			pending = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = {m_tdata, m_tlast, m_tuser};
				if (due_px.size() == 0) begin
					fails++;
					$display({"%0t: unexpected result: expected none, ",
						"actual pixel %0d line_end %b frame_end %b"},
						$time, got.value, got.line_end, got.frame_end);
				end else begin
					want = due_px.pop_front();
					if (got !== want) begin
						fails++;
						$display({"%0t: mismatch: expected pixel %0d line_end %b ",
							"frame_end %b, actual pixel %0d line_end %b frame_end %b"},
							$time, want.value, want.line_end, want.frame_end,
							got.value, got.line_end, got.frame_end);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_FRAME_WIDTH:  frame_w_reg = cfg_data[FW_W-1:0];
					CFG_FRAME_HEIGHT: frame_h_reg = cfg_data[FH_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				sharpen_pixel(s_tuser, s_tdata);
			end
			pending = due_px.size();
		end
	end

endmodule

>>> test/tb_top.sv
// testbench top: clock, reset, pixel stimulus, receiver flow control and the verdict
module tb_top;
	import lsharp_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;   // index with no register behind it
	localparam logic MODE_PIXEL   = 1'b0;
	localparam logic MODE_FLUSH   = 1'b1;
	localparam int   CHOKE_CYCLES = 400;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [PIX_W-1:0]      s_tdata;   // pixel_in
	logic                  s_tuser;   // mode
	logic                  m_tvalid;
	logic                  m_tready;
	logic [PIX_W-1:0]      m_tdata;   // pixel_out
	logic                  m_tlast;   // line_end
	logic                  m_tuser;   // frame_end
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    fails;
	int                    pending;
	int unsigned           frame_w, frame_h;
	int unsigned           fed = 0;
	int unsigned           delivered = 0;
	bit                    choked = 1'b0;

	laplacian_sharpen_3x3 uut (.*);
	sharpen_check sharp_chk (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			delivered <= delivered + 1;
		end
	end

	function automatic int idle_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60) begin
			return 0;
		end
		if (roll < 95) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(4, 25);
	endfunction

	function automatic logic [PIX_W-1:0] rand_pixel();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 2) begin
			return '0;
		end
		if (roll < 4) begin
			return PIX_MAX;
		end
		return PIX_W'($urandom);
	endfunction

	task automatic push_item(input logic mode, input logic [PIX_W-1:0] pix);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= pix;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		fed++;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic set_frame(input int unsigned w_raw, input int unsigned h_raw);
		logic [CFG_DATA_W-1:0] wval;
		wait_idle();
		// junk above the width field must be ignored
		wval = CFG_DATA_W'($urandom);
		wval[FW_W-1:0] = FW_W'(w_raw);
		write_reg(CFG_FRAME_WIDTH, wval);
		write_reg(CFG_FRAME_HEIGHT, FH_W'(h_raw));
		if ($urandom_range(0, 3) == 0) begin
			write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
		end
		cfg_valid <= 1'b0;
		frame_w = (w_raw == 0) ? 1 : (w_raw > MAX_WIDTH_DEFAULT) ? MAX_WIDTH_DEFAULT : w_raw;
		frame_h = (h_raw == 0) ? 1 : h_raw;
	endtask

	// whole frame plus drain, with the odd early flush and stray pixel in the drain
	task automatic send_frame();
		for (int unsigned n = 0; n < frame_w * frame_h; n++) begin
			push_item(($urandom_range(0, 19) == 0) ? MODE_FLUSH : MODE_PIXEL, rand_pixel());
		end
		for (int unsigned n = 0; n <= frame_w; n++) begin
			push_item(($urandom_range(0, 9) == 0) ? MODE_PIXEL : MODE_FLUSH, rand_pixel());
		end
	endtask

	// receiver with random stalls and one long hold-off while items keep coming
	initial begin
		int gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!choked && delivered >= 150 && s_tvalid) begin
				m_tready <= 1'b0;
				repeat (CHOKE_CYCLES) @(posedge clk);
				choked = 1'b1;
			end
			gap = idle_len();
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	initial begin
		logic [PIX_W:0] opening [13];
		int unsigned    start, w_pick;
		int             roll;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tuser   = MODE_PIXEL;
		s_tdata   = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_FRAME_WIDTH;
		cfg_data  = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// checkerboard: saturation both ways, early flush, stray pixel in the drain
		opening = '{{MODE_PIXEL, PIX_MAX}, {MODE_PIXEL, 8'd0}, {MODE_PIXEL, PIX_MAX},
			{MODE_PIXEL, 8'd0}, {MODE_PIXEL, PIX_MAX}, {MODE_PIXEL, 8'd0},
			{MODE_PIXEL, 8'd1}, {MODE_FLUSH, 8'd200}, {MODE_PIXEL, 8'd254},
			{MODE_FLUSH, 8'd0}, {MODE_PIXEL, 8'd77}, {MODE_FLUSH, PIX_MAX},
			{MODE_FLUSH, 8'd0}};
		set_frame(3, 3);
		foreach (opening[k]) begin
			push_item(opening[k][PIX_W], opening[k][PIX_W-1:0]);
		end

		// width lowered under the column counter in the first line
		set_frame(8, 2);
		for (int k = 0; k < 5; k++) begin
			push_item(MODE_PIXEL, PIX_W'(10 * (k + 1)));
		end
		wait_idle();
		write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(3));
		cfg_valid <= 1'b0;
		for (int k = 0; k < 4; k++) begin
			push_item(MODE_PIXEL, PIX_W'(60 + 10 * k));
		end
		for (int k = 0; k < 4; k++) begin
			push_item(MODE_FLUSH, PIX_MAX);
		end

		// zero width and height act as one
		set_frame(0, 0);
		send_frame();

		start = fed;
		while (fed - start < 440) begin
			if ($urandom_range(0, 1) == 0) begin
				roll = $urandom_range(0, 19);
				if (roll < 14) begin
					w_pick = $urandom_range(1, 8);
				end else if (roll < 19) begin
					w_pick = $urandom_range(9, 24);
				end else begin
					w_pick = $urandom_range(25, 64);
				end
				set_frame(w_pick, (w_pick > 24) ? $urandom_range(1, 2) : $urandom_range(1, 6));
			end
			send_frame();
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		for (int n = 0; n < 5000 && pending != 0; n++) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fails == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/lsharp_pkg.sv
rtl/core/lsharp_line_store.sv
rtl/core/laplacian_sharpen_3x3.sv
test/sharpen_check.sv
test/tb_top.sv
